// ===== rtl/core/bps_pkg.sv =====
package bps_pkg;

    // Configuration register indexes
    localparam int REG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_MID  = 3'd1,
        REG_PATTERN_HIGH = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_DIGIT_MODE   = 3'd4
    } cfg_reg_t;

    // Pattern storage is fixed by the three 64-bit registers
    localparam int PATTERN_SLOTS = 24;
    localparam int SLOT_W        = 5;
    localparam int LEN_W         = 5;
    localparam int NEED_W        = 6;
    localparam int DIGIT_EXTRA   = 2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_t;

    // Pattern setup shared by every cell of the chain
    typedef struct packed {
        pattern_t               pattern;
        logic [LEN_W-1:0]       length;
        logic [NEED_W-1:0]      need;
    } match_cfg_t;

    // Control bits handed from the scan stage to the tracker
    typedef struct packed {
        logic hit;
        logic first;
        logic last;
    } scan_ctrl_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

endpackage

// ===== rtl/core/bps_in_if.sv =====
interface bps_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [63:0] chunk_base;
    logic        first_of_chunk;
    logic        last_of_chunk;

    modport source (output valid, data_byte, chunk_base, first_of_chunk, last_of_chunk,
                    input ready);
    modport sink   (input valid, data_byte, chunk_base, first_of_chunk, last_of_chunk,
                    output ready);
endinterface

// ===== rtl/core/bps_out_if.sv =====
interface bps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/core/bps_cell.sv =====
module bps_cell #(
    parameter int POS = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                clear,
    input  logic                flush,
    input  logic [7:0]          byte_in,
    input  bps_pkg::match_cfg_t cfg,
    output logic [7:0]          feed_out,
    output logic                ok
);
    import bps_pkg::*;

    localparam logic [NEED_W-1:0] POS_N = NEED_W'(POS);

    logic [7:0]        byte_reg;
    logic [7:0]        byte_next;
    logic [NEED_W-1:0] k;

    // Byte handed to the neighbor: zero when a new chunk starts
    assign feed_out = clear ? 8'd0 : byte_reg;

    // Pattern slot this window position lines up with
    assign k = cfg.need - POS_N - NEED_W'(1);

    always_comb
    begin
        if (POS_N >= cfg.need)
        begin
            ok = 1'b1;
        end
        else if (k < NEED_W'(cfg.length))
        begin
            ok = (k < NEED_W'(PATTERN_SLOTS)) &&
                 (byte_in == cfg.pattern[k[SLOT_W-1:0]]);
        end
        else
        begin
            ok = is_digit(byte_in);
        end
    end

    assign byte_next = flush ? 8'd0 : byte_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else if (advance)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

// ===== rtl/core/bps_track.sv =====
module bps_track #(
    parameter int INDEX_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  scan_valid,
    input  bps_pkg::scan_ctrl_t   scan_ctrl,
    input  logic [INDEX_BITS-1:0] scan_start,
    input  logic [63:0]           scan_base,
    output logic                  take,
    bps_out_if.source             result
);
    import bps_pkg::*;

    logic                  valid_reg;
    logic                  found_reg;
    logic [63:0]           offset_reg;
    logic                  seen_reg;
    logic                  seen_next;
    logic [INDEX_BITS-1:0] start_reg;
    logic [INDEX_BITS-1:0] start_next;
    logic                  seen_eff;
    logic                  found_now;
    logic [INDEX_BITS-1:0] start_sel;

    // A non-final word never needs the output slot
    assign take = scan_valid &&
                  (!scan_ctrl.last || !valid_reg || result.ready);

    // First match of the chunk wins
    assign seen_eff   = scan_ctrl.first ? 1'b0 : seen_reg;
    assign found_now  = seen_eff || scan_ctrl.hit;
    assign start_sel  = seen_eff ? start_reg : scan_start;
    assign seen_next  = scan_ctrl.last ? 1'b0 : found_now;
    assign start_next = (!seen_eff && scan_ctrl.hit) ? scan_start : start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                seen_reg <= seen_next;
            end
            if (take && scan_ctrl.last)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload: start index and the result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg <= start_next;
        end
        if (take && scan_ctrl.last)
        begin
            found_reg  <= found_now;
            offset_reg <= found_now ? (scan_base + 64'(start_sel)) : 64'd0;
        end
    end

    assign result.valid        = valid_reg;
    assign result.found        = found_reg;
    assign result.match_offset = offset_reg;

endmodule

// ===== rtl/core/byte_pattern_scanner_unit.sv =====
// Channel      Dir  Fields                                              Handshake
// byte_stream  in   data_byte, chunk_base, first_of_chunk, last_of_chunk valid/ready
// result       out  found, match_offset                                 valid/ready
// cfg          in   cfg_write_en, cfg_index, cfg_data                   write strobe
//
// One byte is accepted per cycle while the scan stage is not stalled; a result is registered
// in the scan stage and then in the result register. The cell chain compares the whole window each cycle.
// Reset clears the window, byte count, match tracking and configuration at once.
// A held result stalls the next last byte in the scan stage and every word behind it;
// bytes ahead of that last byte keep flowing.
module byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN_BYTES = 24,
    parameter int INDEX_BITS        = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bps_in_if.sink                             byte_stream,
    bps_out_if.source                          result,
    input  logic                               cfg_write_en,
    input  logic [bps_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bps_pkg::*;

    localparam int WINDOW_DEPTH = MAX_PATTERN_BYTES + DIGIT_EXTRA;

    // Configuration registers
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_mid_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic             digit_mode_reg;
    match_cfg_t       mcfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg    <= 64'd0;
            pat_mid_reg    <= 64'd0;
            pat_high_reg   <= 64'd0;
            pat_len_reg    <= '0;
            digit_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg    <= cfg_data;
                REG_PATTERN_MID:  pat_mid_reg    <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg   <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg    <= cfg_data[LEN_W-1:0];
                REG_DIGIT_MODE:   digit_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign mcfg.pattern = {pat_high_reg, pat_mid_reg, pat_low_reg};
    assign mcfg.length  = pat_len_reg;
    assign mcfg.need    = NEED_W'(pat_len_reg) +
                          (digit_mode_reg ? NEED_W'(DIGIT_EXTRA) : NEED_W'(0));

    // Handshake between input and scan stage
    logic       accept;
    logic       take;
    logic       scan_valid_reg;
    logic       first_in;
    logic       last_in;

    assign first_in          = byte_stream.first_of_chunk;
    assign last_in           = byte_stream.last_of_chunk;
    assign byte_stream.ready = !scan_valid_reg || take;
    assign accept            = byte_stream.valid && byte_stream.ready;

    // Cell chain: each cell holds one window byte and passes it on
    logic [7:0]             chain [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] cell_ok;

    assign chain[0] = byte_stream.data_byte;

    for (genvar j = 0; j < WINDOW_DEPTH; j++)
    begin : g_cell
        if (j < WINDOW_DEPTH - 1)
        begin : g_mid
            bps_cell #(.POS(j)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (accept),
                .clear    (first_in),
                .flush    (last_in),
                .byte_in  (chain[j]),
                .cfg      (mcfg),
                .feed_out (chain[j+1]),
                .ok       (cell_ok[j])
            );
        end
        else
        begin : g_end
            bps_cell #(.POS(j)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (accept),
                .clear    (first_in),
                .flush    (last_in),
                .byte_in  (chain[j]),
                .cfg      (mcfg),
                .feed_out (),
                .ok       (cell_ok[j])
            );
        end
    end

    // Saturating byte count of the current chunk
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_eff;
    logic [INDEX_BITS-1:0] count_next;
    logic                  hit;

    assign count_eff  = first_in ? '0 : count_reg;
    assign count_next = (&count_eff) ? count_eff : count_eff + 1'b1;

    assign hit = (&cell_ok) && (pat_len_reg != '0) &&
                 (pat_len_reg <= LEN_W'(MAX_PATTERN_BYTES)) &&
                 (count_next >= INDEX_BITS'(mcfg.need));

    // Chunk base and scan stage registers
    logic [63:0]           base_reg;
    logic [63:0]           base_eff;
    scan_ctrl_t            scan_ctrl_reg;
    logic [INDEX_BITS-1:0] scan_start_reg;
    logic [63:0]           scan_base_reg;

    assign base_eff = first_in ? byte_stream.chunk_base : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            base_reg       <= 64'd0;
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg      <= last_in ? '0 : count_next;
                base_reg       <= base_eff;
                scan_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                scan_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scan_ctrl_reg.hit   <= hit;
            scan_ctrl_reg.first <= first_in;
            scan_ctrl_reg.last  <= last_in;
            scan_start_reg      <= count_next - INDEX_BITS'(mcfg.need);
            scan_base_reg       <= base_eff;
        end
    end

    // Match tracking and result register
    bps_track #(.INDEX_BITS(INDEX_BITS)) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid_reg),
        .scan_ctrl  (scan_ctrl_reg),
        .scan_start (scan_start_reg),
        .scan_base  (scan_base_reg),
        .take       (take),
        .result     (result)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bps_pkg::*;

    localparam int MAX_BYTES     = 24;
    localparam int COUNT_BITS    = 32;
    localparam int WINDOW_DEPTH  = MAX_BYTES + 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 850;

    typedef struct packed {
        logic [7:0]  data;
        logic [63:0] base;
        logic        first;
        logic        last;
    } stream_word_t;

    typedef struct packed {
        logic        found;
        logic [63:0] offset;
    } scan_report_t;

    logic clk;
    logic rst_n;
    logic                   cfg_write_en;
    logic [REG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bps_in_if  scan_in ();
    bps_out_if scan_out ();

    byte_pattern_scanner_unit #(
        .MAX_PATTERN_BYTES (MAX_BYTES),
        .INDEX_BITS        (COUNT_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (scan_in),
        .result       (scan_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Local copy of the pattern setup
    logic [63:0] pat_low;
    logic [63:0] pat_mid;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    logic        digit_mode;

    // Chunk tracking state
    logic [7:0]            window_bytes [WINDOW_DEPTH];
    logic [COUNT_BITS-1:0] chunk_count;
    logic [63:0]           chunk_origin;
    logic                  hit_seen;
    logic [63:0]           hit_index;

    stream_word_t word_q [$];
    scan_report_t expected_reports [$];
    stream_word_t next_word;
    bit           steady;
    int unsigned  fail_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 14);
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [63:0] reg_word;
        case (k / 8)
            0:       reg_word = pat_low;
            1:       reg_word = pat_mid;
            default: reg_word = pat_high;
        endcase
        return reg_word[(k % 8) * 8 +: 8];
    endfunction

    // Window ends with the literal bytes followed by the digit suffix
    function automatic bit window_holds(input int lit, input int need);
        for (int k = 0; k < lit; k++)
            if (window_bytes[need - 1 - k] != pattern_byte(k))
                return 1'b0;
        for (int k = lit; k < need; k++)
            if (window_bytes[need - 1 - k] < ASCII_ZERO || window_bytes[need - 1 - k] > ASCII_NINE)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_chunk();
        foreach (window_bytes[i])
            window_bytes[i] = 8'h00;
        chunk_count = '0;
        hit_seen    = 1'b0;
        hit_index   = '0;
    endfunction

    // Advance the scan by one accepted word; queue a report on a last byte
    function automatic void scan_byte(input logic [7:0] data, input logic [63:0] base,
                                      input logic first, input logic last);
        int lit;
        int need;
        lit  = pat_len;
        need = lit + (digit_mode ? 2 : 0);
        if (first)
        begin
            clear_chunk();
            chunk_origin = base;
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--)
            window_bytes[k] = window_bytes[k - 1];
        window_bytes[0] = data;
        if (chunk_count != '1)
            chunk_count = chunk_count + 1'b1;
        if (!hit_seen && lit != 0 && lit <= MAX_BYTES && 64'(chunk_count) >= 64'(need)
            && window_holds(lit, need))
        begin
            hit_seen  = 1'b1;
            hit_index = 64'(chunk_count) - 64'(need);
        end
        if (last)
        begin
            expected_reports.push_back('{hit_seen, hit_seen ? chunk_origin + hit_index : 64'd0});
            clear_chunk();
        end
    endfunction

    // Byte stream driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scan_in.valid <= 1'b0;
        end
        else
        begin
            if (scan_in.valid && scan_in.ready)
                scan_byte(scan_in.data_byte, scan_in.chunk_base, scan_in.first_of_chunk,
                          scan_in.last_of_chunk);
            if (!scan_in.valid || scan_in.ready)
            begin
                if (word_q.size() != 0 && !take_break())
                begin
                    next_word                = word_q.pop_front();
                    scan_in.valid           <= 1'b1;
                    scan_in.data_byte       <= next_word.data;
                    scan_in.chunk_base      <= next_word.base;
                    scan_in.first_of_chunk  <= next_word.first;
                    scan_in.last_of_chunk   <= next_word.last;
                end
                else
                begin
                    scan_in.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor and checker
    always @(posedge clk)
    begin
        scan_report_t want;
        if (!rst_n)
        begin
            scan_out.ready <= 1'b0;
        end
        else
        begin
            if (scan_out.valid && scan_out.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: found=%0b match_offset=%h",
                           scan_out.found, scan_out.match_offset);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (scan_out.found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, scan_out.found);
                        fail_count++;
                    end
                    if (scan_out.match_offset !== want.offset)
                    begin
                        $error("match_offset: expected %h, got %h",
                               want.offset, scan_out.match_offset);
                        fail_count++;
                    end
                end
            end
            scan_out.ready <= !take_break();
        end
    end

    task automatic push_word(input logic [7:0] data, input logic [63:0] base,
                             input logic first, input logic last);
        word_q.push_back('{data, base, first, last});
    endtask

    // Register write; only issued while the scanner is idle
    task automatic set_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  pat_low    = value;
            REG_PATTERN_MID:  pat_mid    = value;
            REG_PATTERN_HIGH: pat_high   = value;
            REG_PATTERN_LEN:  pat_len    = value[4:0];
            REG_DIGIT_MODE:   digit_mode = value[0];
            default: ;
        endcase
    endtask

    // Wait until every word is taken and every report is back, then let the pipe drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (word_q.size() != 0 || scan_in.valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Filler leans on pattern bytes, digits and digit borders to provoke near misses
    function automatic logic [7:0] filler_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return 8'($urandom());
        else if (pick < 7)
            return (pat_len != 0) ? pattern_byte($urandom_range(pat_len > MAX_BYTES ?
                                                 MAX_BYTES - 1 : pat_len - 1))
                                  : 8'($urandom());
        else if (pick < 9)
            return 8'(ASCII_ZERO + $urandom_range(9));
        else
            return $urandom_range(1) ? ASCII_ZERO - 8'd1 : ASCII_NINE + 8'd1;
    endfunction

    // Build one chunk with a few planted occurrences; returns words pushed
    task automatic push_chunk(input int len, input bit with_first, input int plants,
                              output int pushed);
        logic [7:0]  chunk_bytes [64];
        logic [63:0] base;
        int lit;
        int need;
        int pos;
        lit  = pat_len;
        need = lit + (digit_mode ? 2 : 0);
        base = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40) : rand64();
        for (int i = 0; i < len; i++)
            chunk_bytes[i] = filler_byte();
        for (int p = 0; p < plants; p++)
        begin
            if (lit != 0 && lit <= MAX_BYTES && len >= need)
            begin
                pos = $urandom_range(len - need, 0);
                for (int i = 0; i < lit; i++)
                    chunk_bytes[pos + i] = pattern_byte(i);
                for (int i = lit; i < need; i++)
                    chunk_bytes[pos + i] = 8'(ASCII_ZERO + $urandom_range(9));
            end
        end
        // Occasional stray first flag inside the chunk restarts it
        for (int i = 0; i < len; i++)
            push_word(chunk_bytes[i], (i == 0) ? base : rand64(),
                      (i == 0) ? with_first : ($urandom_range(49) == 0), i == len - 1);
        pushed = len;
    endtask

    function automatic logic [63:0] two_letter_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[i * 8 +: 8] = $urandom_range(1) ? "A" : "B";
        return w;
    endfunction

    initial
    begin
        int random_words;
        int phase_words;
        int phase_goal;
        int pushed;
        int lit;
        int need;
        int pick;
        int len;
        logic [63:0] len_word;

        rst_n                  = 1'b0;
        cfg_write_en           = 1'b0;
        cfg_index              = REG_PATTERN_LOW;
        cfg_data               = '0;
        scan_in.valid          = 1'b0;
        scan_in.data_byte      = 8'h00;
        scan_in.chunk_base     = '0;
        scan_in.first_of_chunk = 1'b0;
        scan_in.last_of_chunk  = 1'b0;
        scan_out.ready         = 1'b0;
        pat_low                = '0;
        pat_mid                = '0;
        pat_high               = '0;
        pat_len                = '0;
        digit_mode             = 1'b0;
        chunk_origin           = '0;
        steady                 = 1'b0;
        fail_count             = 0;
        clear_chunk();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero length after reset never matches, even on an all-zero chunk
        push_word(8'h00, 64'd5, 1'b1, 1'b0);
        push_word(8'h00, rand64(), 1'b0, 1'b0);
        push_word(8'h00, rand64(), 1'b0, 1'b1);
        wait_idle();

        // Zero length in digit mode
        set_reg(REG_DIGIT_MODE, 64'd1);
        push_word(8'h00, 64'd9, 1'b1, 1'b0);
        push_word("0", rand64(), 1'b0, 1'b0);
        push_word("0", rand64(), 1'b0, 1'b1);
        wait_idle();

        // One-byte pattern: one-byte chunk, offset wrap, chunk without first flag
        set_reg(REG_PATTERN_LOW, 64'h41);
        set_reg(REG_PATTERN_LEN, 64'd1);
        set_reg(REG_DIGIT_MODE, 64'd0);
        push_word("A", 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        push_word("x", 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
        push_word("y", rand64(), 1'b0, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b1);
        push_word("B", rand64(), 1'b0, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b1);
        wait_idle();

        // Two letters plus digits: short chunk, then a colon breaking the first try
        set_reg(REG_PATTERN_LOW, 64'h4241);
        set_reg(REG_PATTERN_LEN, 64'd2);
        set_reg(REG_DIGIT_MODE, 64'd1);
        push_word("A", 64'd100, 1'b1, 1'b0);
        push_word("B", rand64(), 1'b0, 1'b0);
        push_word("0", rand64(), 1'b0, 1'b1);
        push_word("A", 64'd200, 1'b1, 1'b0);
        push_word("B", rand64(), 1'b0, 1'b0);
        push_word(":", rand64(), 1'b0, 1'b0);
        push_word("0", rand64(), 1'b0, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b0);
        push_word("B", rand64(), 1'b0, 1'b0);
        push_word("0", rand64(), 1'b0, 1'b0);
        push_word("9", rand64(), 1'b0, 1'b1);
        wait_idle();

        // Length field too long; upper register bits must be ignored
        set_reg(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        set_reg(REG_DIGIT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        push_word("A", 64'd7, 1'b1, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b0);
        push_word("A", rand64(), 1'b0, 1'b1);
        wait_idle();

        // Random phases, each with a fresh pattern setup
        random_words = 0;
        for (int phase = 0; random_words < RANDOM_WORDS; phase++)
        begin
            pick = $urandom_range(19);
            if (phase < 2)
                lit = MAX_BYTES;
            else if (pick < 12)
                lit = $urandom_range(1, 4);
            else if (pick < 15)
                lit = $urandom_range(5, MAX_BYTES - 1);
            else if (pick < 17)
                lit = MAX_BYTES;
            else if (pick < 18)
                lit = 0;
            else
                lit = $urandom_range(MAX_BYTES + 1, 31);

            if (phase == 0)
            begin
                set_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                set_reg(REG_PATTERN_MID, 64'hFFFF_FFFF_FFFF_FFFF);
                set_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            else if ($urandom_range(2) == 0)
            begin
                set_reg(REG_PATTERN_LOW, two_letter_word());
                set_reg(REG_PATTERN_MID, two_letter_word());
                set_reg(REG_PATTERN_HIGH, two_letter_word());
            end
            else
            begin
                set_reg(REG_PATTERN_LOW, rand64());
                set_reg(REG_PATTERN_MID, rand64());
                set_reg(REG_PATTERN_HIGH, rand64());
            end
            len_word      = rand64();
            len_word[4:0] = 5'(lit);
            set_reg(REG_PATTERN_LEN, len_word);
            set_reg(REG_DIGIT_MODE, (phase == 0) ? 64'd1 : (phase == 1) ? 64'd0 : rand64());

            // One phase runs with no back-pressure or gaps at all
            @(negedge clk);
            steady = (phase == 2);

            need        = pat_len + (digit_mode ? 2 : 0);
            phase_goal  = $urandom_range(50, 110);
            phase_words = 0;
            while (phase_words < phase_goal)
            begin
                if (pat_len != 0 && pat_len <= MAX_BYTES)
                    len = $urandom_range(need > 3 ? need - 2 : 1, need + 12);
                else
                    len = $urandom_range(1, 20);
                push_chunk(len, $urandom_range(9) != 0, $urandom_range(2), pushed);
                phase_words += pushed;
            end
            random_words += phase_words;
            wait_idle();
            @(negedge clk);
            steady = 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bps_pkg.sv
rtl/core/bps_in_if.sv
rtl/core/bps_out_if.sv
rtl/core/bps_cell.sv
rtl/core/bps_track.sv
rtl/core/byte_pattern_scanner_unit.sv
verif/tb.sv
